// File: rtl/core/sorted_table_insert_delete_macros.svh
// ----------------------------------------------------------------------------
// Sorted table assertion macros
// Concurrent check wrappers that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_INSERT_DELETE_MACROS_SVH
`define SORTED_TABLE_INSERT_DELETE_MACROS_SVH

`ifndef SYNTHESIS
// Hold prop on every clock edge outside reset.
`define STID_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sorted table check failed");
// Require cons in the cycle after ante.
`define STID_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sorted table sequence check failed");
`else
`define STID_ASSERT(lbl, clk, rstn, prop)
`define STID_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/stid_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table package
// Sizes, command and status codes, and the control bundle sent to the cells.
// ----------------------------------------------------------------------------
package stid_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic signed [VAL_W-1:0] value;
  } stid_ctl_t;

  // Per-cell compare results.
  typedef struct packed {
    logic lt;
    logic eq;
  } stid_flag_t;

endpackage

// File: rtl/core/stid_cell.sv
// ----------------------------------------------------------------------------
// Sorted table cell
// Holds one entry, compares it with the broadcast value and shifts with its
// neighbors on insert or delete.
// ----------------------------------------------------------------------------
module stid_cell (
  input  logic                                clk,
  input  stid_pkg::stid_ctl_t                 ctl,
  input  logic                                occ,        // entry is in use
  input  logic                                prv_lt,     // left neighbor below value
  input  logic signed [stid_pkg::VAL_W-1:0]   prv_entry,
  input  logic signed [stid_pkg::VAL_W-1:0]   nxt_entry,
  output stid_pkg::stid_flag_t                flag,
  output logic signed [stid_pkg::VAL_W-1:0]   entry
);

  logic signed [stid_pkg::VAL_W-1:0] entry_r;
  logic signed [stid_pkg::VAL_W-1:0] entry_nxt;

  always_comb begin
    flag.lt   = occ && (entry_r < ctl.value);
    flag.eq   = occ && (entry_r == ctl.value);
    entry_nxt = entry_r;
    if (ctl.ins && !flag.lt) begin
      // first cell at or above the value takes it, the rest shift up
      entry_nxt = prv_lt ? ctl.value : prv_entry;
    end else if (ctl.del && !flag.lt) begin
      entry_nxt = nxt_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// File: rtl/core/sorted_table_insert_delete.sv
// ----------------------------------------------------------------------------
// Sorted table with insert, delete and search
// Row of compare-and-shift cells keeping signed 32-bit entries in order.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_*) carry a command and a value: clear, insert in sorted
//   place, delete first match, or search. Each beat gives exactly one result
//   beat (out_*) with status, the 1-based match index of a search, the entry
//   count, empty/full flags and the smallest and largest entry (0 if empty).
//   Result path: the holding stage loads when the input beat is taken, and the
//   result then moves to the output register once that register is free.
//   Throughput: one beat per cycle unless stalled. Every cell compares against
//   the broadcast value and shifts with its neighbor in the same cycle, so the
//   whole table updates together; the result stage then reads the row ends.
//   Stall: a pending result waits in a holding stage while the output register
//   is full; in_tready drops only when both are occupied and out_tready is low.
//   Reset: the count goes to zero and both result stages empty. Entry storage
//   is not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
`include "sorted_table_insert_delete_macros.svh"

module sorted_table_insert_delete (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] command, [33:2] value, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata   // [1:0] status, [8:2] found_index,
                                  // [15:9] entry_count, [16] is_empty,
                                  // [17] is_full, [49:18] min_value,
                                  // [81:50] max_value, rest zero
);

  localparam int N  = stid_pkg::CAPACITY;
  localparam int CW = stid_pkg::CNT_W;
  localparam int VW = stid_pkg::VAL_W;

  // Input decode
  logic                 in_fire;
  stid_pkg::cmd_t       cmd;
  logic signed [VW-1:0] value;

  assign in_fire = in_tvalid && in_tready;
  assign cmd     = stid_pkg::cmd_t'(in_tdata[1:0]);
  assign value   = in_tdata[33:2];

  // Table state
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  logic [N-1:0]         occ;
  logic [N-1:0]         lt_v;
  logic [N-1:0]         eq_v;
  logic signed [VW-1:0] entry_v [N];
  stid_pkg::stid_flag_t flag_v [N];
  stid_pkg::stid_ctl_t  ctl;

  logic          full;
  logic          found_any;
  logic [CW-1:0] hit_idx;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      occ[i]  = count_r > CW'(i);
      lt_v[i] = flag_v[i].lt;
      eq_v[i] = flag_v[i].eq;
    end
  end

  assign full      = count_r == CW'(N);
  assign found_any = |eq_v;

  // Encode the first equal cell: sorted order means its left neighbor is below.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (eq_v[i] && ((i == 0) || lt_v[(i == 0) ? 0 : i - 1])) begin
        hit_idx = hit_idx | CW'(i + 1);
      end
    end
  end

  assign ctl.ins   = in_fire && (cmd == stid_pkg::CMD_INSERT) && !full;
  assign ctl.del   = in_fire && (cmd == stid_pkg::CMD_DELETE) && found_any;
  assign ctl.value = value;

  // Row of cells; row ends get fixed neighbors
  for (genvar g = 0; g < N; g++) begin : g_row
    logic                 prv_lt;
    logic signed [VW-1:0] prv_entry;
    logic signed [VW-1:0] nxt_entry;
    if (g == 0) begin : g_first
      assign prv_lt    = 1'b1;
      assign prv_entry = value;
    end else begin : g_mid
      assign prv_lt    = lt_v[g-1];
      assign prv_entry = entry_v[g-1];
    end
    if (g == N - 1) begin : g_last
      assign nxt_entry = entry_v[g];
    end else begin : g_inner
      assign nxt_entry = entry_v[g+1];
    end
    stid_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ[g]),
      .prv_lt    (prv_lt),
      .prv_entry (prv_entry),
      .nxt_entry (nxt_entry),
      .flag      (flag_v[g]),
      .entry     (entry_v[g])
    );
  end

  // Command outcome
  stid_pkg::status_t status_nxt;
  logic [CW-1:0]     found_nxt;

  always_comb begin
    count_nxt  = count_r;
    status_nxt = stid_pkg::ST_OK;
    found_nxt  = '0;
    if (in_fire) begin
      case (cmd)
        stid_pkg::CMD_CLEAR: begin
          count_nxt = '0;
        end
        stid_pkg::CMD_INSERT: begin
          if (full) begin
            status_nxt = stid_pkg::ST_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        stid_pkg::CMD_DELETE: begin
          if (found_any) begin
            count_nxt = count_r - 1'b1;
          end else begin
            status_nxt = stid_pkg::ST_NOT_FOUND;
          end
        end
        stid_pkg::CMD_SEARCH: begin
          found_nxt = found_any ? hit_idx : '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  // Holding stage: status and index wait here until the output register frees
  logic              p_r;
  logic              p_nxt;
  stid_pkg::status_t p_status_r;
  logic [CW-1:0]     p_found_r;
  logic              out_tvalid_r;
  logic              out_tvalid_nxt;
  logic              out_free;
  logic [87:0]       out_data_r;

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = !p_r || out_free;
  assign p_nxt     = in_fire || (p_r && !out_free);

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_free) begin
      out_tvalid_nxt = p_r;
    end
  end

  // Row ends, read from the table as it stands after the pending command
  logic signed [VW-1:0] min_val;
  logic signed [VW-1:0] max_val;
  logic [31:0]          cnt_ext;
  logic [31:0]          fnd_ext;
  logic [87:0]          out_data_nxt;

  always_comb begin
    max_val = '0;
    for (int i = 0; i < N; i++) begin
      if (occ[i] && ((i == N - 1) || !occ[(i == N - 1) ? i : i + 1])) begin
        max_val = max_val | entry_v[i];
      end
    end
  end

  assign min_val = occ[0] ? entry_v[0] : '0;
  assign cnt_ext = 32'(count_r);
  assign fnd_ext = 32'(p_found_r);

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[1:0]   = p_status_r;
    out_data_nxt[8:2]   = fnd_ext[6:0];
    out_data_nxt[15:9]  = cnt_ext[6:0];
    out_data_nxt[16]    = count_r == '0;
    out_data_nxt[17]    = full;
    out_data_nxt[49:18] = min_val;
    out_data_nxt[81:50] = max_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      p_r          <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      p_r          <= p_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload: capture on accept, move to output when the register frees
  always_ff @(posedge clk) begin
    if (in_fire) begin
      p_status_r <= status_nxt;
      p_found_r  <= found_nxt;
    end
    if (out_free && p_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // Checks
  `STID_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(N))
  `STID_ASSERT_NEXT(a_clear_empties, clk, rst_n,
    in_fire && (cmd == stid_pkg::CMD_CLEAR), count_r == '0)
  `STID_ASSERT_NEXT(a_insert_grows, clk, rst_n,
    in_fire && (cmd == stid_pkg::CMD_INSERT) && !full, count_r == $past(count_r) + 1'b1)
  `STID_ASSERT_NEXT(a_miss_keeps, clk, rst_n,
    in_fire && (cmd == stid_pkg::CMD_DELETE) && !found_any, $stable(count_r))
  `STID_ASSERT(a_stall_blocks, clk, rst_n, !(p_r && out_tvalid_r && !out_tready) || !in_tready)

endmodule
